@@ src/ip_address_text_validator_top_defines.svh @@
// Assertion macros used by the top level of the address validator.
`ifndef IP_ADDRESS_TEXT_VALIDATOR_TOP_DEFINES_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define IPV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("address validator: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define IPV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("address validator: next-cycle check failed");

`endif

@@ src/ipv_pkg.sv @@
// Shared types, character codes and limits of the address validator.
package ipv_pkg;

  // Address kinds carried in tuser bit 0
  localparam logic TYPE_V4 = 1'b0;
  localparam logic TYPE_V6 = 1'b1;

  // Separator characters
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Field limits
  localparam logic [2:0] V4_MAX_DIGITS  = 3'd3;
  localparam logic [3:0] V4_MAX_DOTS    = 4'd3;
  localparam logic [9:0] V4_MAX_BYTE    = 10'd255;
  localparam logic [2:0] V6_MAX_DIGITS  = 3'd4;
  localparam logic [3:0] V6_MAX_GROUPS  = 4'd8;
  localparam logic [3:0] V6_MAX_COMPACT = V6_MAX_GROUPS - 4'd1;

  // One character beat after the input register
  typedef struct packed {
    logic       address_type;
    logic       has_char;
    logic [7:0] char_code;
    logic       last;
  } beat_t;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

endpackage

@@ src/ipv_in_reg.sv @@
// Input register: holds one character beat until the scanner takes it.
module ipv_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]    s_axis_tuser,   // [0] address_type, [1] has_char
  input  logic          s_axis_tlast,
  input  logic          out_free,
  output ipv_pkg::beat_t beat,
  output logic          step
);
  import ipv_pkg::*;

  logic in_valid;

  // Advance the held beat unless it ends a string and the result slot is busy
  assign step          = in_valid && (!beat.last || out_free);
  assign s_axis_tready = !in_valid || step;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      beat.address_type <= s_axis_tuser[0];
      beat.has_char     <= s_axis_tuser[1];
      beat.char_code    <= s_axis_tdata;
      beat.last         <= s_axis_tlast;
    end
  end

endmodule

@@ src/ipv_scan.sv @@
// Scanner: running parse state and the verdict at the end of a string.
module ipv_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  ipv_pkg::beat_t beat,
  output logic           verdict
);
  import ipv_pkg::*;

  logic       failed, failed_next;
  logic [2:0] digit_count, digit_count_next;
  logic [9:0] byte_value, byte_value_next;
  logic [3:0] group_count, group_count_next;
  logic       seen_double_colon, seen_double_colon_next;
  logic       prev_was_colon, prev_was_colon_next;
  logic       lone_leading_colon, lone_leading_colon_next;
  logic       any_colon_seen, any_colon_seen_next;

  logic [13:0] times10;
  logic [7:0]  c;

  assign c       = beat.char_code;
  assign times10 = {1'b0, byte_value, 3'b000} + {3'b000, byte_value, 1'b0};

  // Apply one character
  always_comb begin
    failed_next             = failed;
    digit_count_next        = digit_count;
    byte_value_next         = byte_value;
    group_count_next        = group_count;
    seen_double_colon_next  = seen_double_colon;
    prev_was_colon_next     = prev_was_colon;
    lone_leading_colon_next = lone_leading_colon;
    any_colon_seen_next     = any_colon_seen;
    if (beat.has_char) begin
      if (beat.address_type == TYPE_V6) begin
        if (is_hex(c)) begin
          if (lone_leading_colon) failed_next = 1'b1;
          if (digit_count >= V6_MAX_DIGITS) begin
            failed_next = 1'b1;
          end else begin
            digit_count_next = digit_count + 3'd1;
          end
          prev_was_colon_next = 1'b0;
        end else if (c == CHAR_COLON) begin
          if (digit_count != 3'd0) begin
            // close a group
            if (group_count >= V6_MAX_GROUPS) begin
              failed_next = 1'b1;
            end else begin
              group_count_next = group_count + 4'd1;
            end
            digit_count_next    = 3'd0;
            prev_was_colon_next = 1'b1;
          end else if (prev_was_colon) begin
            // second colon of a double colon
            if (seen_double_colon) failed_next = 1'b1;
            seen_double_colon_next  = 1'b1;
            prev_was_colon_next     = 1'b0;
            lone_leading_colon_next = 1'b0;
          end else if (any_colon_seen) begin
            failed_next         = 1'b1;
            prev_was_colon_next = 1'b1;
          end else begin
            lone_leading_colon_next = 1'b1;
            prev_was_colon_next     = 1'b1;
          end
          any_colon_seen_next = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end else begin
        if (is_dec(c)) begin
          if (digit_count >= V4_MAX_DIGITS) begin
            failed_next = 1'b1;
          end else begin
            digit_count_next = digit_count + 3'd1;
            byte_value_next  = times10[9:0] + {6'd0, c[3:0]};
          end
        end else if (c == CHAR_DOT) begin
          if (digit_count == 3'd0 || byte_value > V4_MAX_BYTE) failed_next = 1'b1;
          if (group_count >= V4_MAX_DOTS) begin
            failed_next = 1'b1;
          end else begin
            group_count_next = group_count + 4'd1;
          end
          digit_count_next = 3'd0;
          byte_value_next  = 10'd0;
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  // Judge the string as it stands after this character
  always_comb begin
    logic       fin_failed;
    logic [3:0] fin_groups;
    fin_failed = failed_next;
    fin_groups = group_count_next;
    verdict    = 1'b0;
    if (beat.address_type == TYPE_V6) begin
      if (digit_count_next != 3'd0) begin
        if (group_count_next >= V6_MAX_GROUPS) begin
          fin_failed = 1'b1;
        end else begin
          fin_groups = group_count_next + 4'd1;
        end
      end else if (prev_was_colon_next) begin
        fin_failed = 1'b1;
      end
      if (!fin_failed && any_colon_seen_next) begin
        verdict = seen_double_colon_next ? (fin_groups <= V6_MAX_COMPACT)
                                         : (fin_groups == V6_MAX_GROUPS);
      end
    end else begin
      if (digit_count_next == 3'd0 || byte_value_next > V4_MAX_BYTE) fin_failed = 1'b1;
      verdict = !fin_failed && (group_count_next == V4_MAX_DOTS);
    end
  end

  // Load the new state, or clear it once a string is judged
  always_ff @(posedge clk) begin
    if (rst || (step && beat.last)) begin
      failed             <= 1'b0;
      digit_count        <= 3'd0;
      byte_value         <= 10'd0;
      group_count        <= 4'd0;
      seen_double_colon  <= 1'b0;
      prev_was_colon     <= 1'b0;
      lone_leading_colon <= 1'b0;
      any_colon_seen     <= 1'b0;
    end else if (step) begin
      failed             <= failed_next;
      digit_count        <= digit_count_next;
      byte_value         <= byte_value_next;
      group_count        <= group_count_next;
      seen_double_colon  <= seen_double_colon_next;
      prev_was_colon     <= prev_was_colon_next;
      lone_leading_colon <= lone_leading_colon_next;
      any_colon_seen     <= any_colon_seen_next;
    end
  end

endmodule

@@ src/ipv_out_reg.sv @@
// Result register: holds one verdict until the receiver takes it.
module ipv_out_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       verdict,
  output logic       out_free,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] valid_res, [7:1] zero
);
  import ipv_pkg::*;

  logic out_valid;
  logic out_res;

  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res};

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= verdict;
    end
  end

endmodule

@@ src/ip_address_text_validator_top.sv @@
// Top level of the IPv4/IPv6 address text validator.
//
// Input stream: one character per beat. tdata[7:0] is the ASCII code,
// tuser[0] picks the address kind (0 IPv4, 1 IPv6), tuser[1] marks that the
// beat carries a character (low only for an empty string), tlast marks the
// final beat of a string.
// Output stream: one beat per string, tdata[0] is 1 when the text is a
// valid address of the given kind.
// Throughput: one character beat per cycle, strings back to back, unless a final beat waits for the result register.
// The edge that accepts the last beat loads the input register; the verdict
// then passes through the parse logic into the result register at an edge
// where that register is free, and the register drives m_axis_tvalid.
// Reset clears the parse state and both holding registers; nothing is
// pending afterward. While the receiver stalls, the result register holds
// its beat; characters of the next string keep flowing, and only a further
// final beat waits in the input register, which then drops s_axis_tready.
`include "ip_address_text_validator_top_defines.svh"

module ip_address_text_validator_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic [1:0] s_axis_tuser,   // [0] address_type, [1] has_char
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] valid_res, [7:1] zero
);
  import ipv_pkg::*;

  beat_t beat;
  logic  step;
  logic  out_free;
  logic  verdict;
  logic  finish;

  assign finish = step && beat.last;

  ipv_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .out_free      (out_free),
    .beat          (beat),
    .step          (step)
  );

  ipv_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .beat    (beat),
    .verdict (verdict)
  );

  ipv_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (finish),
    .verdict       (verdict),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Input stalls only behind a waiting result
  `IPV_ASSERT_SAME(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // A finished string shows its verdict on the next cycle
  `IPV_ASSERT_NEXT(a_finish_shows, finish, m_axis_tvalid)
  // A new verdict always follows a finished string
  `IPV_ASSERT_SAME(a_no_spurious, $rose(m_axis_tvalid), $past(finish))

endmodule
